@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BQE_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define BQE_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define BQE_ASSERT_IMP(lbl, a, b)
`define BQE_ASSERT_NXT(lbl, a, b)
`endif
`endif

@@ rtl/bqe_pkg.sv @@
// Types, constants and helpers of the billboard quad expander.
`default_nettype none
package bqe_pkg;
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RIGHT_X = 3'd0,
    CFG_RIGHT_Y = 3'd1,
    CFG_RIGHT_Z = 3'd2,
    CFG_UP_X    = 3'd3,
    CFG_UP_Y    = 3'd4,
    CFG_UP_Z    = 3'd5
  } cfg_idx_t;

  localparam logic [2:0] LastVtx = 3'd5;
  localparam logic [1:0] TexPos  = 2'b01;
  localparam logic [1:0] TexNeg  = 2'b11;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [15:0]        size;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic               last;
  } part_t;

  typedef struct packed {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
  } cam_t;

  typedef struct packed {
    part_t       p;
    logic [15:0] alpha;
    logic        r_neg;
    logic        u_neg;
    logic        last_vtx;
    logic        eob;
  } vreq_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
    logic [15:0]        alpha;
    logic [1:0]         tex_u;
    logic [1:0]         tex_v;
    logic               last_vtx;
    logic               eob;
  } vout_t;

  // {right negative, up negative} for vertex k of triangles (0,1,2),(0,2,3)
  function automatic logic [1:0] corner_signs(input logic [2:0] k);
    logic [1:0] s;
    unique case (k)
      3'd0: s = 2'b11;
      3'd1: s = 2'b01;
      3'd2: s = 2'b00;
      3'd3: s = 2'b11;
      3'd4: s = 2'b00;
      3'd5: s = 2'b10;
      default: s = 2'b11;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

@@ rtl/bqe_alpha_pipe.sv @@
// Fade alpha pipeline: operand prep then a pipelined restoring divider.
`default_nettype none
module bqe_alpha_pipe (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire bqe_pkg::part_t in_p,
  input  wire logic [15:0]   in_life,
  input  wire logic [15:0]   in_total,
  output logic               out_valid,
  output bqe_pkg::part_t     out_p,
  output logic [15:0]        out_alpha
);
  import bqe_pkg::*;

  localparam int DivStages = 8;
  localparam int BitsPerStage = 16 / DivStages;

  function automatic logic [33:0] div_step(input logic [17:0] rem, input logic [15:0] nq,
                                           input logic [17:0] den);
    logic [18:0] t;
    logic [17:0] r;
    logic [15:0] q;
    r = rem;
    q = nq;
    for (int i = 0; i < BitsPerStage; i++) begin
      t = {r, q[15]};
      q = {q[14:0], 1'b0};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
        q[0] = 1'b1;
      end
      r = t[17:0];
    end
    return {r, q};
  endfunction

  logic        v0_r;
  part_t       p0_r;
  logic [15:0] l0_r, t0_r;

  logic [DivStages:0] v_r;
  part_t       p_r    [0:DivStages];
  logic [17:0] den_r  [0:DivStages];
  logic [17:0] rem_r  [0:DivStages];
  logic [15:0] nq_r   [0:DivStages];
  logic        dead_r [0:DivStages];
  logic        full_r [0:DivStages];

  logic [34:0] num;
  logic [17:0] den;
  logic        full;
  logic [33:0] step_res [1:DivStages];

  assign num  = 35'(l0_r) * 35'd327675;
  assign den  = 18'(t0_r) * 18'd3;
  assign full = (19'(l0_r) * 19'd5) >= (19'(t0_r) * 19'd3);

  always_comb begin
    for (int g = 1; g <= DivStages; g++) begin
      step_res[g] = div_step(rem_r[g-1], nq_r[g-1], den_r[g-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v_r  <= '0;
    end else if (en) begin
      v0_r <= in_valid;
      v_r  <= {v_r[DivStages-1:0], v0_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r      <= in_p;
      l0_r      <= in_life;
      t0_r      <= in_total;
      p_r[0]    <= p0_r;
      den_r[0]  <= den;
      rem_r[0]  <= num[33:16];
      nq_r[0]   <= num[15:0];
      dead_r[0] <= (l0_r == 16'd0) || (t0_r == 16'd0);
      full_r[0] <= full;
      for (int g = 1; g <= DivStages; g++) begin
        p_r[g]    <= p_r[g-1];
        den_r[g]  <= den_r[g-1];
        rem_r[g]  <= step_res[g][33:16];
        nq_r[g]   <= step_res[g][15:0];
        dead_r[g] <= dead_r[g-1];
        full_r[g] <= full_r[g-1];
      end
    end
  end

  assign out_valid = v_r[DivStages];
  assign out_p     = p_r[DivStages];
  assign out_alpha = dead_r[DivStages] ? 16'd0 :
                     full_r[DivStages] ? 16'hFFFF : nq_r[DivStages];
endmodule
`default_nettype wire

@@ rtl/bqe_vertex_seq.sv @@
// Vertex sequencer: holds one particle and issues its six vertex requests.
`default_nettype none
module bqe_vertex_seq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en_v,
  input  wire logic           in_valid,
  input  wire bqe_pkg::part_t in_p,
  input  wire logic [15:0]    in_alpha,
  output logic                take,
  output logic                out_valid,
  output bqe_pkg::vreq_t      out_req
);
  import bqe_pkg::*;

  logic        busy_r;
  logic [2:0]  cnt_r;
  part_t       p_r;
  logic [15:0] alpha_r;
  logic [1:0]  sgn;

  assign take = !busy_r || ((cnt_r == LastVtx) && en_v);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (take) begin
      busy_r <= in_valid;
      cnt_r  <= '0;
    end else if (en_v && busy_r) begin
      cnt_r <= cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p_r     <= in_p;
      alpha_r <= in_alpha;
    end
  end

  assign sgn = corner_signs(cnt_r);

  assign out_valid        = busy_r;
  assign out_req.p        = p_r;
  assign out_req.alpha    = alpha_r;
  assign out_req.r_neg    = sgn[1];
  assign out_req.u_neg    = sgn[0];
  assign out_req.last_vtx = (cnt_r == LastVtx);
  assign out_req.eob      = (cnt_r == LastVtx) && p_r.last;
endmodule
`default_nettype wire

@@ rtl/bqe_pos_pipe.sv @@
// Vertex position pipeline: corner offset, size multiply, round and saturate.
`default_nettype none
module bqe_pos_pipe (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire bqe_pkg::cam_t  cam,
  input  wire logic           in_valid,
  input  wire bqe_pkg::vreq_t in_req,
  output logic                out_valid,
  output bqe_pkg::vout_t      out_vtx
);
  import bqe_pkg::*;

  logic [2:0]  v_r;
  vreq_t       ra_r, rb_r;
  vout_t       vo_r;
  logic signed [17:0] sum_r  [0:2];
  logic signed [34:0] prod_r [0:2];

  logic signed [17:0] rv [0:2];
  logic signed [17:0] uv [0:2];
  logic signed [31:0] cv [0:2];
  logic signed [17:0] sum_nxt  [0:2];
  logic signed [34:0] prod_nxt [0:2];
  logic signed [40:0] acc      [0:2];
  logic signed [33:0] q        [0:2];
  logic signed [31:0] pos_nxt  [0:2];

  always_comb begin
    rv[0] = 18'(cam.rx);
    rv[1] = 18'(cam.ry);
    rv[2] = 18'(cam.rz);
    uv[0] = 18'(cam.ux);
    uv[1] = 18'(cam.uy);
    uv[2] = 18'(cam.uz);
    cv[0] = rb_r.p.cx;
    cv[1] = rb_r.p.cy;
    cv[2] = rb_r.p.cz;
    for (int a = 0; a < 3; a++) begin
      sum_nxt[a]  = (in_req.r_neg ? -rv[a] : rv[a]) + (in_req.u_neg ? -uv[a] : uv[a]);
      prod_nxt[a] = 35'(sum_r[a]) * $signed({19'd0, ra_r.p.size});
      acc[a]      = 41'($signed({cv[a], 7'd0})) + 41'(prod_r[a]) + 41'sd64;
      q[a]        = acc[a][40:7];
      if (q[a] > 34'sh07FFFFFFF) begin
        pos_nxt[a] = 32'sh7FFFFFFF;
      end else if (q[a] < -34'sh080000000) begin
        pos_nxt[a] = 32'sh80000000;
      end else begin
        pos_nxt[a] = q[a][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_r <= in_req;
      rb_r <= ra_r;
      for (int a = 0; a < 3; a++) begin
        sum_r[a]  <= sum_nxt[a];
        prod_r[a] <= prod_nxt[a];
      end
      vo_r.pos_x    <= pos_nxt[0];
      vo_r.pos_y    <= pos_nxt[1];
      vo_r.pos_z    <= pos_nxt[2];
      vo_r.red      <= rb_r.p.red;
      vo_r.green    <= rb_r.p.green;
      vo_r.blue     <= rb_r.p.blue;
      vo_r.alpha    <= rb_r.alpha;
      vo_r.tex_u    <= rb_r.r_neg ? TexNeg : TexPos;
      vo_r.tex_v    <= rb_r.u_neg ? TexNeg : TexPos;
      vo_r.last_vtx <= rb_r.last_vtx;
      vo_r.eob      <= rb_r.eob;
    end
  end

  assign out_valid = v_r[2];
  assign out_vtx   = vo_r;
endmodule
`default_nettype wire

@@ rtl/billboard_quad_expander_unit.sv @@
// Billboard quad expander top level.
// Each particle request expands into six vertex requests (triangles 0-1-2 and
// 0-2-3 of a camera-facing quad), issued one per cycle when the output is not
// stalled, so a particle is taken for every six vertices. The vertex sequencer
// sets that rate. A particle passes the input register, operand prep, eight
// two-bit divider stages for the fade alpha, the sequencer, and three
// position stages ending in the output register.
// The camera registers are written through cfg_* and are expected to change
// only while the block is empty.
`default_nettype none
module billboard_quad_expander_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // center_x, center_y, center_z, quad_size, color_red, color_green,
  // color_blue, life_left, life_total
  input  wire logic [191:0] in_tdata,
  input  wire logic         in_tlast,   // last_particle
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // pos_x, pos_y, pos_z, out_red, out_green, out_blue, alpha, tex_u, tex_v,
  // zero pad
  output logic [167:0]      out_tdata,
  output logic              out_tlast,  // last_vertex
  output logic              out_tuser,  // end_of_batch
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import bqe_pkg::*;

  `include "assert_macros.svh"

  cam_t        cam_r;
  part_t       in_p;
  logic        en_p, en_v;
  logic        ap_valid, take;
  part_t       ap_p;
  logic [15:0] ap_alpha;
  logic        seq_valid;
  vreq_t       seq_req;
  logic        pv_valid;
  vout_t       pv_vtx;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r.rx <= 16'sd16384;
      cam_r.ry <= 16'sd0;
      cam_r.rz <= 16'sd0;
      cam_r.ux <= 16'sd0;
      cam_r.uy <= 16'sd16384;
      cam_r.uz <= 16'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RIGHT_X: cam_r.rx <= cfg_data;
        CFG_RIGHT_Y: cam_r.ry <= cfg_data;
        CFG_RIGHT_Z: cam_r.rz <= cfg_data;
        CFG_UP_X:    cam_r.ux <= cfg_data;
        CFG_UP_Y:    cam_r.uy <= cfg_data;
        CFG_UP_Z:    cam_r.uz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_p.cx    = in_tdata[31:0];
  assign in_p.cy    = in_tdata[63:32];
  assign in_p.cz    = in_tdata[95:64];
  assign in_p.size  = in_tdata[111:96];
  assign in_p.red   = in_tdata[127:112];
  assign in_p.green = in_tdata[143:128];
  assign in_p.blue  = in_tdata[159:144];
  assign in_p.last  = in_tlast;

  assign en_v      = !pv_valid || out_tready;
  assign en_p      = !ap_valid || take;
  assign in_tready = en_p;

  bqe_alpha_pipe u_alpha (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_p),
    .in_valid  (in_tvalid),
    .in_p      (in_p),
    .in_life   (in_tdata[175:160]),
    .in_total  (in_tdata[191:176]),
    .out_valid (ap_valid),
    .out_p     (ap_p),
    .out_alpha (ap_alpha)
  );

  bqe_vertex_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en_v      (en_v),
    .in_valid  (ap_valid),
    .in_p      (ap_p),
    .in_alpha  (ap_alpha),
    .take      (take),
    .out_valid (seq_valid),
    .out_req   (seq_req)
  );

  bqe_pos_pipe u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en_v),
    .cam       (cam_r),
    .in_valid  (seq_valid),
    .in_req    (seq_req),
    .out_valid (pv_valid),
    .out_vtx   (pv_vtx)
  );

  assign out_tvalid = pv_valid;
  assign out_tdata  = {4'd0, pv_vtx.tex_v, pv_vtx.tex_u, pv_vtx.alpha, pv_vtx.blue,
                       pv_vtx.green, pv_vtx.red, pv_vtx.pos_z, pv_vtx.pos_y, pv_vtx.pos_x};
  assign out_tlast  = pv_vtx.last_vtx;
  assign out_tuser  = pv_vtx.eob;

  `BQE_ASSERT_IMP(a_eob_on_last, out_tvalid && out_tuser, out_tlast)
  `BQE_ASSERT_IMP(a_tex_legal, out_tvalid, (out_tdata[161:160] == TexPos || out_tdata[161:160] == TexNeg) && (out_tdata[163:162] == TexPos || out_tdata[163:162] == TexNeg))
  `BQE_ASSERT_NXT(a_seq_holds, seq_valid && !en_v, seq_valid)
endmodule
`default_nettype wire
